/* hdl/nss_pkg.sv */
// ----------------------------------------------------------------------------
// nss_pkg
// Shared types and codes for the note step sequencer.
// ----------------------------------------------------------------------------
package nss_pkg;

    localparam int unsigned PITCH_W = 16;
    localparam int unsigned BEATS_W = 8;
    localparam int unsigned RAND_W  = 8;

    typedef enum logic [2:0] {
        OP_BEAT  = 3'd0,
        OP_PUSH  = 3'd1,
        OP_POP   = 3'd2,
        OP_CLEAR = 3'd3,
        OP_START = 3'd4,
        OP_STOP  = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        EV_ON      = 2'd0,
        EV_OFF     = 2'd1,
        EV_ALL_OFF = 2'd2
    } t_event;

    localparam logic [1:0] MODE_FWD  = 2'd0;
    localparam logic [1:0] MODE_BWD  = 2'd1;
    localparam logic [1:0] MODE_RAND = 2'd2;
    localparam logic [1:0] MODE_HOLD = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CUR,
        S_NEW,
        S_ON
    } t_state;

    typedef struct packed {
        logic signed [PITCH_W-1:0] pitch;
        logic                      is_note;
        logic [BEATS_W-1:0]        beats;
    } t_step;

    typedef struct packed {
        logic [2:0]                op;
        logic signed [PITCH_W-1:0] note_pitch;
        logic                      is_note;
        logic [BEATS_W-1:0]        step_beats;
        logic signed [PITCH_W-1:0] transpose;
        logic [RAND_W-1:0]         random_byte;
    } t_item;

    typedef struct packed {
        logic                      valid;
        t_event                    kind;
        logic signed [PITCH_W-1:0] pitch;
        logic                      last;
    } t_emit;

endpackage

/* hdl/nss_ram.sv */
// ----------------------------------------------------------------------------
// nss_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module nss_ram #(
    parameter int unsigned WIDTH = 25,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

/* hdl/nss_ctrl.sv */
// ----------------------------------------------------------------------------
// nss_ctrl
// Sequencer control: decodes words, reads and updates the step table,
// tracks play state and produces note events.
// ----------------------------------------------------------------------------
module nss_ctrl #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  nss_pkg::t_item                 i_item,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_mode,
    input  logic                           i_out_ok,
    output nss_pkg::t_emit                 o_emit,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_rd_addr,
    input  nss_pkg::t_step                 i_rd_data,
    output logic                           o_wr_en,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_wr_addr,
    output nss_pkg::t_step                 o_wr_data
);

    import nss_pkg::*;

    localparam int unsigned IW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam logic signed [33:0] SAT_HI = (34'sd1 <<< (PITCH_W - 1)) - 34'sd1;
    localparam logic signed [33:0] SAT_LO = -SAT_HI - 34'sd1;

    function automatic logic signed [PITCH_W-1:0] sat_pitch(
        input logic signed [PITCH_W-1:0] p,
        input logic signed [PITCH_W-1:0] off
    );
        logic signed [PITCH_W:0] sum;
        logic signed [33:0]      wide;
        sum  = {p[PITCH_W-1], p} + {off[PITCH_W-1], off};
        wide = 34'(sum);
        if (wide > SAT_HI) begin
            wide = SAT_HI;
        end else if (wide < SAT_LO) begin
            wide = SAT_LO;
        end
        return wide[PITCH_W-1:0];
    endfunction

    t_state                    r_state, n_state;
    t_op                       r_op, n_op;
    logic signed [PITCH_W-1:0] r_pitch_in, n_pitch_in;
    logic                      r_note_in, n_note_in;
    logic [BEATS_W-1:0]        r_beats_in, n_beats_in;
    logic signed [PITCH_W-1:0] r_xpose, n_xpose;
    logic [RAND_W-1:0]         r_rand, n_rand;
    logic [CW-1:0]             r_count, n_count;
    logic [IW-1:0]             r_cur, n_cur;
    logic                      r_valid, n_valid;
    logic [BEATS_W-1:0]        r_beats_left, n_beats_left;
    logic                      r_playing, n_playing;
    logic signed [PITCH_W-1:0] r_offset, n_offset;
    logic                      r_off_pend, n_off_pend;
    logic signed [PITCH_W-1:0] r_off_pitch, n_off_pitch;

    logic [CW-1:0]        cnt_m1;
    logic                 cur_in_range;
    logic                 cur_is_top;
    logic                 off_hit;
    logic [CW-1:0]        cur_p1;
    logic [RAND_W+CW-1:0] rand_prod;
    logic [IW-1:0]        next_idx;
    logic signed [PITCH_W-1:0] rd_sat;

    assign cnt_m1       = r_count - 1'b1;
    assign cur_in_range = CW'(r_cur) < r_count;
    assign cur_is_top   = CW'(r_cur) == cnt_m1;
    assign off_hit      = (r_beats_left == BEATS_W'(1)) && r_valid && cur_in_range
                          && i_rd_data.is_note;
    assign cur_p1       = CW'(r_cur) + 1'b1;
    assign rand_prod    = (RAND_W + CW)'(r_rand) * (RAND_W + CW)'(r_count);
    assign rd_sat       = sat_pitch(i_rd_data.pitch, r_offset);

    always_comb begin
        unique case (i_mode)
            MODE_FWD: begin
                if (!r_valid || !cur_in_range || cur_p1 == r_count) begin
                    next_idx = '0;
                end else begin
                    next_idx = IW'(cur_p1);
                end
            end
            MODE_BWD: begin
                if (!r_valid || !cur_in_range || r_cur == '0) begin
                    next_idx = IW'(cnt_m1);
                end else begin
                    next_idx = r_cur - 1'b1;
                end
            end
            MODE_RAND: next_idx = rand_prod[RAND_W +: IW];
            MODE_HOLD: next_idx = r_cur;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_cur        <= '0;
            r_valid      <= 1'b0;
            r_beats_left <= '0;
            r_playing    <= 1'b0;
            r_offset     <= '0;
            r_off_pend   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_cur        <= n_cur;
            r_valid      <= n_valid;
            r_beats_left <= n_beats_left;
            r_playing    <= n_playing;
            r_offset     <= n_offset;
            r_off_pend   <= n_off_pend;
        end
        r_op        <= n_op;
        r_pitch_in  <= n_pitch_in;
        r_note_in   <= n_note_in;
        r_beats_in  <= n_beats_in;
        r_xpose     <= n_xpose;
        r_rand      <= n_rand;
        r_off_pitch <= n_off_pitch;
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_pitch_in   = r_pitch_in;
        n_note_in    = r_note_in;
        n_beats_in   = r_beats_in;
        n_xpose      = r_xpose;
        n_rand       = r_rand;
        n_count      = r_count;
        n_cur        = r_cur;
        n_valid      = r_valid;
        n_beats_left = r_beats_left;
        n_playing    = r_playing;
        n_offset     = r_offset;
        n_off_pend   = r_off_pend;
        n_off_pitch  = r_off_pitch;
        o_emit       = '0;
        o_in_ready   = (r_state == S_IDLE);
        o_wr_en      = 1'b0;
        o_wr_addr    = r_count[IW-1:0];
        o_wr_data    = '{pitch: r_pitch_in, is_note: r_note_in, beats: r_beats_in};

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op       = t_op'(i_item.op);
                    n_pitch_in = i_item.note_pitch;
                    n_note_in  = i_item.is_note;
                    n_beats_in = i_item.step_beats;
                    n_xpose    = i_item.transpose;
                    n_rand     = i_item.random_byte;
                    n_state    = S_CUR;
                end
            end
            S_CUR: begin
                unique case (r_op)
                    OP_BEAT: begin
                        if (!r_playing || r_count == '0) begin
                            n_state = S_IDLE;
                        end else if (r_beats_left > BEATS_W'(1)) begin
                            n_beats_left = r_beats_left - 1'b1;
                            n_state      = S_IDLE;
                        end else if (i_mode == MODE_HOLD) begin
                            if (!off_hit || i_out_ok) begin
                                o_emit       = '{valid: off_hit, kind: EV_OFF,
                                                 pitch: rd_sat, last: 1'b1};
                                n_beats_left = '0;
                                n_state      = S_IDLE;
                            end
                        end else begin
                            n_cur       = next_idx;
                            n_valid     = 1'b1;
                            n_off_pend  = off_hit;
                            n_off_pitch = rd_sat;
                            n_state     = S_NEW;
                        end
                    end
                    OP_PUSH: begin
                        if (r_count < CW'(TABLE_DEPTH)) begin
                            o_wr_en = 1'b1;
                            n_count = r_count + 1'b1;
                        end
                        n_state = S_IDLE;
                    end
                    OP_POP: begin
                        if (r_count == '0) begin
                            n_state = S_IDLE;
                        end else if (r_playing && r_valid && cur_is_top) begin
                            if (!i_rd_data.is_note || i_out_ok) begin
                                o_emit       = '{valid: i_rd_data.is_note, kind: EV_OFF,
                                                 pitch: rd_sat, last: 1'b1};
                                n_beats_left = '0;
                                n_count      = cnt_m1;
                                n_state      = S_IDLE;
                            end
                        end else begin
                            n_count = cnt_m1;
                            n_state = S_IDLE;
                        end
                    end
                    OP_CLEAR: begin
                        if (!r_playing || i_out_ok) begin
                            o_emit  = '{valid: r_playing, kind: EV_ALL_OFF,
                                        pitch: '0, last: 1'b1};
                            n_count = '0;
                            n_state = S_IDLE;
                        end
                    end
                    OP_START: begin
                        if (!r_playing) begin
                            n_offset  = r_xpose;
                            n_playing = 1'b1;
                        end
                        n_state = S_IDLE;
                    end
                    OP_STOP: begin
                        if (!r_playing) begin
                            n_state = S_IDLE;
                        end else if (i_out_ok) begin
                            o_emit       = '{valid: 1'b1, kind: EV_ALL_OFF,
                                             pitch: '0, last: 1'b1};
                            n_playing    = 1'b0;
                            n_valid      = 1'b0;
                            n_cur        = '0;
                            n_beats_left = '0;
                            n_state      = S_IDLE;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_NEW: begin
                if (r_off_pend) begin
                    if (i_out_ok) begin
                        o_emit       = '{valid: 1'b1, kind: EV_OFF, pitch: r_off_pitch,
                                         last: !i_rd_data.is_note};
                        n_off_pend   = 1'b0;
                        n_beats_left = i_rd_data.beats;
                        n_state      = i_rd_data.is_note ? S_ON : S_IDLE;
                    end
                end else if (!i_rd_data.is_note || i_out_ok) begin
                    o_emit       = '{valid: i_rd_data.is_note, kind: EV_ON,
                                     pitch: rd_sat, last: 1'b1};
                    n_beats_left = i_rd_data.beats;
                    n_state      = S_IDLE;
                end
            end
            S_ON: begin
                if (i_out_ok) begin
                    o_emit  = '{valid: 1'b1, kind: EV_ON, pitch: rd_sat, last: 1'b1};
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    assign o_rd_addr = n_cur;

endmodule

/* hdl/note_step_sequencer.sv */
// ----------------------------------------------------------------------------
// note_step_sequencer
// Step sequencer with a stored table of note steps and beat-driven playback.
// ----------------------------------------------------------------------------
// A word is accepted in S_IDLE, which also addresses the step table, and is acted
// on in S_CUR with the entry read back; no new word is taken before the return
// to S_IDLE. Outside hold mode a beat that ends a step reads the table again for
// the new entry in S_NEW, and also passes through S_ON when it sends both note-off
// and note-on. The single read port of the step table and the one-deep event
// register set this order; a stalled event output holds the sequencer in place.
module note_step_sequencer #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,   // order_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,       // note_pitch, is_note, step_beats, transpose,
                                       // random_byte, zero fill
    input  logic [2:0]  s_tuser,       // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,       // out_pitch
    output logic [1:0]  m_tuser,       // event_kind
    output logic        m_tlast
);

    import nss_pkg::*;

    localparam int unsigned IW = $clog2(TABLE_DEPTH);

    logic [1:0]  r_mode;
    logic        r_m_valid;
    t_event      r_m_kind;
    logic [15:0] r_m_pitch;
    logic        r_m_last;

    t_item   item;
    t_emit   emit;
    logic    out_ok;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    logic          wr_en;
    t_step         wr_data;
    t_step         rd_data;

    assign item = '{op:          s_tuser,
                    note_pitch:  s_tdata[15:0],
                    is_note:     s_tdata[16],
                    step_beats:  s_tdata[24:17],
                    transpose:   s_tdata[40:25],
                    random_byte: s_tdata[48:41]};

    assign out_ok = !r_m_valid || m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_FWD;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (emit.valid) begin
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
        if (emit.valid) begin
            r_m_kind  <= emit.kind;
            r_m_pitch <= emit.pitch;
            r_m_last  <= emit.last;
        end
    end

    nss_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .i_item     (item),
        .o_in_ready (s_tready),
        .i_mode     (r_mode),
        .i_out_ok   (out_ok),
        .o_emit     (emit),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data)
    );

    nss_ram #(
        .WIDTH ($bits(t_step)),
        .DEPTH (TABLE_DEPTH)
    ) u_step_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_pitch;
    assign m_tuser  = r_m_kind;
    assign m_tlast  = r_m_last;

endmodule

/* tb/note_step_sequencer_tb.sv */
// ----------------------------------------------------------------------------
// note_step_sequencer_tb
// Self-checking bench for the note step sequencer. A scripted opening walks
// reset behavior, field extremes, saturation and the edit and playback corner
// cases. Random phases then run every step order, including hold.
// A built-in sequencer model predicts the note events of words with no scripted list.
// Both stream sides idle at random, and one long output stall backs up input.
// ----------------------------------------------------------------------------
module note_step_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nss_pkg::*;

    localparam logic [2:0]  OP_SPARE6      = 3'd6;
    localparam logic [2:0]  OP_SPARE7      = 3'd7;
    localparam logic [1:0]  BY_MODEL       = 2'd3;
    localparam int unsigned N_SCRIPT       = 26;
    localparam int unsigned N_PHASES       = 7;
    localparam int unsigned PRESS_CYCLES   = 300;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES  = 8;

    typedef struct packed {
        t_event      kind;
        logic [15:0] pitch;
        logic        last;
    } note_event_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] pitch;
        logic        is_note;
        logic [7:0]  beats;
        logic [15:0] xpose;
        logic [7:0]  rnd;
        logic [1:0]  n;
        t_event      k0;
        logic [15:0] p0;
        t_event      k1;
        logic [15:0] p1;
    } script_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;      // note_pitch, is_note, step_beats, transpose, random_byte, zeros
    logic [2:0]  s_tuser;      // operation
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;      // out_pitch
    logic [1:0]  m_tuser;      // event_kind
    logic        m_tlast;

    // typed expectation of the word on the input bus
    logic [1:0]  row_n;
    t_event      row_k0;
    t_event      row_k1;
    logic [15:0] row_p0;
    logic [15:0] row_p1;

    note_event_t pending_events[$];
    note_event_t new_events[$];
    int unsigned mismatches;
    int unsigned stalled_cycles;
    bit          tx_idle_on;
    bit          rx_idle_on;
    bit          press_req;
    bit          press_done;

    // sequencer state as predicted
    t_step              steps [16];
    int unsigned        n_steps;
    int unsigned        play_idx;
    bit                 idx_ok;
    int unsigned        beats_rem;
    bit                 running;
    logic signed [15:0] offset;
    logic [1:0]         order;

    note_step_sequencer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [15:0] sounded(logic signed [15:0] p);
        int s;
        s = int'(p) + int'(offset);
        if (s > 32767) return 16'h7fff;
        if (s < -32768) return 16'h8000;
        return s[15:0];
    endfunction

    function automatic void add_event(t_event k, logic [15:0] p);
        note_event_t e;
        e.kind  = k;
        e.pitch = p;
        e.last  = 1'b0;
        new_events.push_back(e);
    endfunction

    function automatic void advance_sequencer(logic [2:0] op, logic [15:0] pitch,
                                              logic is_note, logic [7:0] beats,
                                              logic [15:0] xpose, logic [7:0] rnd);
        int unsigned nxt;
        case (op)
            OP_BEAT: begin
                if (!running || n_steps == 0) return;
                if (beats_rem == 1 && idx_ok && play_idx < n_steps && steps[play_idx].is_note)
                    add_event(EV_OFF, sounded(steps[play_idx].pitch));
                if (beats_rem > 1) begin
                    beats_rem--;
                    return;
                end
                beats_rem = 0;
                case (order)
                    MODE_FWD: nxt = (!idx_ok || play_idx >= n_steps) ? 0
                                  : (play_idx + 1) % n_steps;
                    MODE_BWD: nxt = (!idx_ok || play_idx >= n_steps) ? n_steps - 1
                                  : (play_idx + n_steps - 1) % n_steps;
                    MODE_RAND: nxt = (int'(rnd) * n_steps) >> 8;
                    default: return;
                endcase
                play_idx  = nxt;
                idx_ok    = 1'b1;
                beats_rem = steps[nxt].beats;
                if (steps[nxt].is_note)
                    add_event(EV_ON, sounded(steps[nxt].pitch));
            end
            OP_PUSH: begin
                if (n_steps < 16) begin
                    steps[n_steps].pitch   = pitch;
                    steps[n_steps].is_note = is_note;
                    steps[n_steps].beats   = beats;
                    n_steps++;
                end
            end
            OP_POP: begin
                if (n_steps == 0) return;
                if (running && idx_ok && play_idx == n_steps - 1) begin
                    if (steps[play_idx].is_note)
                        add_event(EV_OFF, sounded(steps[play_idx].pitch));
                    beats_rem = 0;
                end
                n_steps--;
            end
            OP_CLEAR: begin
                if (running) add_event(EV_ALL_OFF, 16'h0000);
                n_steps = 0;
            end
            OP_START: begin
                if (!running) begin
                    offset  = xpose;
                    running = 1'b1;
                end
            end
            OP_STOP: begin
                if (running) begin
                    running = 1'b0;
                    add_event(EV_ALL_OFF, 16'h0000);
                    idx_ok    = 1'b0;
                    play_idx  = 0;
                    beats_rem = 0;
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin : monitor
        note_event_t want;
        if (!i_rst_n) begin
            n_steps   = 0;
            play_idx  = 0;
            idx_ok    = 1'b0;
            beats_rem = 0;
            running   = 1'b0;
            offset    = '0;
            order     = MODE_FWD;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_events.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected word: kind %0d pitch %h last %0d",
                             $time, m_tuser, m_tdata, m_tlast);
                end else begin
                    want = pending_events.pop_front();
                    if (want.kind !== m_tuser || want.pitch !== m_tdata ||
                        want.last !== m_tlast) begin
                        mismatches++;
                        $display("%0t: mismatch: expected kind %0d pitch %h last %0d,",
                                 $time, want.kind, want.pitch, want.last,
                                 " got kind %0d pitch %h last %0d",
                                 m_tuser, m_tdata, m_tlast);
                    end
                end
            end
            if (i_cfg_we) order = i_cfg_wdata;
            if (s_tvalid && s_tready) begin
                new_events.delete();
                advance_sequencer(s_tuser, s_tdata[15:0], s_tdata[16], s_tdata[24:17],
                                  s_tdata[40:25], s_tdata[48:41]);
                if (row_n != BY_MODEL) begin
                    new_events.delete();
                    if (row_n >= 2'd1) add_event(row_k0, row_p0);
                    if (row_n == 2'd2) add_event(row_k1, row_p1);
                end
                if (new_events.size() > 0) new_events[new_events.size() - 1].last = 1'b1;
                foreach (new_events[i]) pending_events.push_back(new_events[i]);
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || i_cfg_we)
            stalled_cycles = 0;
        else
            stalled_cycles++;
    end

    initial begin
        while (stalled_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("[note_step_sequencer] ERROR");
        $finish;
    end

    initial begin : sink
        int unsigned hold_left;
        hold_left = 0;
        m_tready  = 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (press_req && !press_done) begin
                press_done = 1'b1;
                hold_left  = PRESS_CYCLES - 1;
                m_tready  <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
                hold_left = $urandom_range(0, 15);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic offer_word(logic [2:0] op, logic [15:0] pitch, logic is_note,
                              logic [7:0] beats, logic [15:0] xpose, logic [7:0] rnd,
                              logic [1:0] n, t_event k0, logic [15:0] p0,
                              t_event k1, logic [15:0] p1);
        if (tx_idle_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, rnd, xpose, beats, is_note, pitch};
        row_n    <= n;
        row_k0   <= k0;
        row_p0   <= p0;
        row_k1   <= k1;
        row_p1   <= p1;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [15:0] edge_or_any();
        case ($urandom_range(0, 7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        script_row_t script [N_SCRIPT];
        logic [1:0]  phase_order [N_PHASES];
        int unsigned r;
        logic [2:0]  op;
        logic [7:0]  beats;

        script = '{
            '{OP_BEAT,   16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00, 2'd0, EV_ON, 16'h0, EV_ON, 16'h0},
            '{OP_POP,    16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00, 2'd0, EV_ON, 16'h0, EV_ON, 16'h0},
            '{OP_STOP,   16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00, 2'd0, EV_ON, 16'h0, EV_ON, 16'h0},
            '{OP_SPARE6, 16'hffff, 1'b1, 8'hff, 16'hffff, 8'hff, 2'd0, EV_ON, 16'h0, EV_ON, 16'h0},
            '{OP_PUSH,   16'h7fff, 1'b1, 8'h01, 16'h0000, 8'h00, 2'd0, EV_ON, 16'h0, EV_ON, 16'h0},
            '{OP_PUSH,   16'h8000, 1'b1, 8'h00, 16'h0000, 8'h00, 2'd0, EV_ON, 16'h0, EV_ON, 16'h0},
            '{OP_PUSH,   16'h0100, 1'b0, 8'hff, 16'h0000, 8'h00, 2'd0, EV_ON, 16'h0, EV_ON, 16'h0},
            '{OP_PUSH,   16'h1234, 1'b1, 8'h02, 16'h0000, 8'h00, 2'd0, EV_ON, 16'h0, EV_ON, 16'h0},
            '{OP_START,  16'h0000, 1'b0, 8'h00, 16'h7fff, 8'h00, 2'd0, EV_ON, 16'h0, EV_ON, 16'h0},
            '{OP_START,  16'h0000, 1'b0, 8'h00, 16'h8000, 8'h00, 2'd0, EV_ON, 16'h0, EV_ON, 16'h0},
            '{OP_BEAT,   16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00, 2'd1,
              EV_ON, 16'h7fff, EV_ON, 16'h0},
            '{OP_BEAT,   16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00, 2'd2,
              EV_OFF, 16'h7fff, EV_ON, 16'hffff},
            '{OP_BEAT,   16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00, 2'd0, EV_ON, 16'h0, EV_ON, 16'h0},
            '{OP_BEAT,   16'h0000, 1'b0, 8'h00, 16'h0000, 8'ha5, BY_MODEL,
              EV_ON, 16'h0, EV_ON, 16'h0},
            '{OP_POP,    16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00, BY_MODEL,
              EV_ON, 16'h0, EV_ON, 16'h0},
            '{OP_POP,    16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00, BY_MODEL,
              EV_ON, 16'h0, EV_ON, 16'h0},
            '{OP_BEAT,   16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00, 2'd1,
              EV_ON, 16'h7fff, EV_ON, 16'h0},
            '{OP_POP,    16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00, 2'd0, EV_ON, 16'h0, EV_ON, 16'h0},
            '{OP_POP,    16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00, 2'd1,
              EV_OFF, 16'h7fff, EV_ON, 16'h0},
            '{OP_BEAT,   16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00, 2'd0, EV_ON, 16'h0, EV_ON, 16'h0},
            '{OP_CLEAR,  16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00, 2'd1,
              EV_ALL_OFF, 16'h0000, EV_ON, 16'h0},
            '{OP_STOP,   16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00, 2'd1,
              EV_ALL_OFF, 16'h0000, EV_ON, 16'h0},
            '{OP_START,  16'h0000, 1'b0, 8'h00, 16'h8000, 8'h00, 2'd0, EV_ON, 16'h0, EV_ON, 16'h0},
            '{OP_PUSH,   16'h8000, 1'b1, 8'h01, 16'h0000, 8'h00, 2'd0, EV_ON, 16'h0, EV_ON, 16'h0},
            '{OP_BEAT,   16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00, 2'd1,
              EV_ON, 16'h8000, EV_ON, 16'h0},
            '{OP_STOP,   16'h0000, 1'b0, 8'h00, 16'h0000, 8'h00, 2'd1,
              EV_ALL_OFF, 16'h0000, EV_ON, 16'h0}
        };
        phase_order = '{MODE_BWD, MODE_RAND, MODE_FWD, MODE_HOLD, MODE_RAND, MODE_BWD, MODE_FWD};

        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = MODE_FWD;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = OP_BEAT;
        row_n          = BY_MODEL;
        row_k0         = EV_ON;
        row_k1         = EV_ON;
        row_p0         = '0;
        row_p1         = '0;
        mismatches     = 0;
        stalled_cycles = 0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        press_req      = 1'b0;
        press_done     = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (script[i])
            offer_word(script[i].op, script[i].pitch, script[i].is_note, script[i].beats,
                       script[i].xpose, script[i].rnd, script[i].n,
                       script[i].k0, script[i].p0, script[i].k1, script[i].p1);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            i_cfg_we    <= 1'b1;
            i_cfg_wdata <= phase_order[ph];
            @(negedge i_clk);
            i_cfg_we   <= 1'b0;
            tx_idle_on  = (ph != 2 && ph != N_PHASES - 1);
            rx_idle_on  = tx_idle_on;
            press_req   = (ph == 0);
            for (int k = 0; k < ((phase_order[ph] == MODE_HOLD) ? 40 : 150); k++) begin
                r = $urandom_range(0, 99);
                if (r < 50)      op = OP_BEAT;
                else if (r < 68) op = OP_PUSH;
                else if (r < 76) op = OP_POP;
                else if (r < 79) op = OP_CLEAR;
                else if (r < 91) op = OP_START;
                else if (r < 96) op = OP_STOP;
                else             op = $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;
                r = $urandom_range(0, 19);
                if (r < 14)      beats = 8'($urandom_range(0, 3));
                else if (r < 19) beats = 8'($urandom_range(0, 15));
                else             beats = 8'($urandom);
                offer_word(op, edge_or_any(), $urandom_range(0, 3) != 0, beats,
                           edge_or_any(), 8'($urandom), BY_MODEL,
                           EV_ON, 16'h0, EV_ON, 16'h0);
            end
        end

        s_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (mismatches == 0)
            $display("[note_step_sequencer] OK");
        else
            $display("[note_step_sequencer] ERROR");
        $finish;
    end

endmodule
